[rtl/core/fes_pkg.sv]
package fes_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned ACC_W  = 17;
  localparam int unsigned OPA_W  = 8;
  localparam int unsigned PH_W   = 2;
  localparam int unsigned DIVD_W = TICK_W + OPA_W;

  localparam logic [PH_W-1:0] PH_FADE_IN  = 2'd0;
  localparam logic [PH_W-1:0] PH_HOLD     = 2'd1;
  localparam logic [PH_W-1:0] PH_FADE_OUT = 2'd2;
  localparam logic [PH_W-1:0] PH_DONE     = 2'd3;

  localparam logic [1:0] REG_FADE_IN  = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_FADE_OUT = 2'd2;
  localparam logic [1:0] REG_LOOP     = 2'd3;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [TICK_W-1:0] divisor;
  } fes_div_req_t;

endpackage

[rtl/core/fes_div.sv]
// Restoring divider, one quotient bit per cycle. The caller guarantees
// dividend < divisor * 2**OPA_W, so the quotient fits in OPA_W bits.
module fes_div
  import fes_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fes_div_req_t       req,
  output logic               done,
  output logic [OPA_W-1:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(OPA_W);

  logic [TICK_W-1:0] rem_r, rem_nxt;
  logic [OPA_W-1:0]  sh_r, sh_nxt;
  logic [TICK_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [TICK_W:0]   trial;
  logic [TICK_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, sh_r[OPA_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.dividend[DIVD_W-1:OPA_W];
      sh_nxt  = req.dividend[OPA_W-1:0];
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      sh_nxt  = {sh_r[OPA_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OPA_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

[rtl/core/fade_envelope_sequencer.sv]
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready  | tdata: elapsed[15:0]; tuser: kind
// out_    | out | out_tvalid/out_tready| tdata: opacity[7:0], phase[9:8]; tlast: finished
// cfg_    | in  | cfg_wr_en            | cfg_addr (register index), cfg_wdata[15:0]
//
// One request at a time. Start requests, phase ends and the hold phase go from accept
// through the emit state to the output register; a ramp step first goes through the
// divider's load, the bit-serial divider and its write-back, then the emit state.
// Reset is synchronous (rst_n low): hold phase, opacity 255, registers 0.
// A new request is accepted while the previous result still waits on out_.
module fade_envelope_sequencer
  import fes_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [TICK_W-1:0]   in_tdata,   // [15:0] elapsed
  input  logic                in_tuser,   // [0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [7:0] opacity, [9:8] phase, rest zero
  output logic                out_tlast,  // finished
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [TICK_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_DIV_GO, S_DIV_WAIT, S_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [TICK_W-1:0]  fin_r, hold_r, fout_r;
  logic               loop_r;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [ACC_W-1:0]   elapsed_r, elapsed_nxt;
  logic [OPA_W-1:0]   opa_r, opa_nxt;
  logic               fin_flag_r, fin_flag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OPA_W-1:0]   out_opa_r, out_opa_nxt;
  logic [PH_W-1:0]    out_ph_r, out_ph_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [TICK_W-1:0]  acc16;
  fes_div_req_t       div_req;
  logic               div_done;
  logic [OPA_W-1:0]   div_q;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign acc_sum   = {1'b0, elapsed_r} + {2'b0, in_tdata};
  assign acc_sat   = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
  assign acc16     = elapsed_r[TICK_W-1:0];

  // elapsed * 255 = (elapsed << 8) - elapsed; elapsed < len here
  always_comb begin
    div_req.start    = (state_r == S_DIV_GO);
    div_req.dividend = {acc16, {OPA_W{1'b0}}} - {{OPA_W{1'b0}}, acc16};
    div_req.divisor  = (phase_r == PH_FADE_IN) ? fin_r : fout_r;
  end

  fes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    opa_nxt       = opa_r;
    fin_flag_nxt  = fin_flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_opa_nxt   = out_opa_r;
    out_ph_nxt    = out_ph_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_EMIT;
          fin_flag_nxt = 1'b0;
          if (in_tuser == KIND_START) begin
            elapsed_nxt = '0;
            if (fin_r != '0) begin
              phase_nxt = PH_FADE_IN;
              opa_nxt   = '0;
            end else if (fout_r != '0) begin
              phase_nxt = PH_FADE_OUT;
              opa_nxt   = '1;
            end else begin
              phase_nxt = PH_HOLD;
            end
          end else begin
            unique case (phase_r)
              PH_FADE_IN: begin
                elapsed_nxt = acc_sat;
                if (acc_sat >= {1'b0, fin_r}) begin
                  phase_nxt   = PH_HOLD;
                  opa_nxt     = '1;
                  elapsed_nxt = '0;
                end else begin
                  state_nxt = S_DIV_GO;
                end
              end
              PH_FADE_OUT: begin
                elapsed_nxt = acc_sat;
                if (acc_sat >= {1'b0, fout_r}) begin
                  opa_nxt = '0;
                  if (loop_r) begin
                    elapsed_nxt = '0;
                    if (fin_r != '0) begin
                      phase_nxt = PH_FADE_IN;
                    end else begin
                      phase_nxt = PH_HOLD;
                      opa_nxt   = '1;
                    end
                  end else begin
                    phase_nxt    = PH_DONE;
                    fin_flag_nxt = 1'b1;
                  end
                end else begin
                  state_nxt = S_DIV_GO;
                end
              end
              PH_HOLD: begin
                if (hold_r != '0) begin
                  elapsed_nxt = acc_sat;
                  if (acc_sat >= {1'b0, hold_r}) begin
                    if (fout_r != '0) begin
                      phase_nxt   = PH_FADE_OUT;
                      elapsed_nxt = '0;
                    end else if (loop_r) begin
                      elapsed_nxt = '0;
                      if (fin_r != '0) begin
                        phase_nxt = PH_FADE_IN;
                        opa_nxt   = '0;
                      end
                    end else begin
                      phase_nxt    = PH_DONE;
                      fin_flag_nxt = 1'b1;
                    end
                  end
                end
              end
              default: ;  // finished: advance changes nothing but clearing the finished flag
            endcase
          end
        end
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          opa_nxt   = (phase_r == PH_FADE_IN) ? div_q : ~div_q;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_opa_nxt   = opa_r;
          out_ph_nxt    = phase_r;
          out_last_nxt  = fin_flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HOLD;
      elapsed_r   <= '0;
      opa_r       <= '1;
      fin_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fin_r       <= '0;
      hold_r      <= '0;
      fout_r      <= '0;
      loop_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      opa_r       <= opa_nxt;
      fin_flag_r  <= fin_flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_FADE_IN:  fin_r  <= cfg_wdata;
          REG_HOLD:     hold_r <= cfg_wdata;
          REG_FADE_OUT: fout_r <= cfg_wdata;
          REG_LOOP:     loop_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    out_opa_r  <= out_opa_nxt;
    out_ph_r   <= out_ph_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ph_r, out_opa_r};
  assign out_tlast  = out_last_r;

  a_fin_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_ph_r == PH_DONE)
    else $error("finished flag without finished phase");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider result outside wait state");

  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_GO |-> (phase_r == PH_FADE_IN || phase_r == PH_FADE_OUT))
    else $error("ramp division outside a fade phase");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r == S_EMIT))
    else $error("result loaded outside emit state");

endmodule
